// File: hdl/plk_pkg.sv
// Shared types and constants of the printer link packet engine.
`default_nettype none
package plk_pkg;

  localparam int IMAGE_DEPTH_DEF   = 8192;
  localparam int MAX_PACKET_LENGTH = 640;
  localparam int PEND_W            = 10;
  localparam int RD_ADDR_W         = 13;
  localparam int IMG_LEN_W         = 14;
  localparam int LINE_BYTES        = 40;
  // floor(p / 40) == (p * 205) >> 13 for every p below 1024
  localparam int DIV40_MUL         = 205;
  localparam int DIV40_SHIFT       = 13;
  localparam int DIV40_PROD_W      = 18;
  localparam int DIV40_QUOT_W      = 5;

  localparam logic OP_EXCHANGE = 1'b0;
  localparam logic OP_READ     = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [7:0]           link_byte;
    logic [RD_ADDR_W-1:0] read_address;
  } plk_in_t;

  typedef struct packed {
    logic [7:0]           reply_byte;
    logic [7:0]           read_data;
    logic [7:0]           status_now;
    logic                 print_start;
    logic [7:0]           print_margins;
    logic [7:0]           print_palette;
    logic [7:0]           print_exposure;
    logic                 print_appending;
    logic [IMG_LEN_W-1:0] image_length;
  } plk_out_t;

endpackage
`default_nettype wire

// File: hdl/plk_stream_if.sv
// Valid/ready item channel carrying one payload struct.
`default_nettype none
interface plk_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/printer_link_packet_engine.sv
// Printer link packet engine: protocol decoder, image store and result register.
`default_nettype none
// Usage
//   req: one item per link event. operation 0 exchanges link_byte with the
//     console, operation 1 reads the image store at read_address.
//   rsp: one item back for every req item: reply byte, store read data,
//     status byte, PRINT capture and the committed image length.
// Timing
//   Every item is decoded in the cycle it is accepted; protocol state and the
//   store write update at that edge and the result lands in the output
//   register together with the registered store read, so rsp valid rises in
//   the cycle after req acceptance. Throughput is 1 item per cycle while the
//   receiver takes every result.
// Reset
//   rst (synchronous) returns the decoder to waiting for the first magic
//   byte, clears status, counts and PRINT history, and empties rsp. The
//   store contents are not cleared; only committed bytes are meaningful.
// Backpressure
//   req.ready = !rsp.valid || rsp.ready, so a stalled receiver holds one
//   finished item and blocks further input until it is taken.
module printer_link_packet_engine #(
  parameter int IMAGE_DEPTH = plk_pkg::IMAGE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  plk_stream_if.sink   req,
  plk_stream_if.source rsp
);

  localparam int ADDR_W = $clog2(IMAGE_DEPTH);
  localparam int CNT_W  = $clog2(IMAGE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMP_W  = (CNT_W > plk_pkg::RD_ADDR_W) ? CNT_W : plk_pkg::RD_ADDR_W;
  localparam int PW     = plk_pkg::PEND_W;

  // Protocol phases
  localparam logic [2:0] PH_MAGIC    = 3'd0;
  localparam logic [2:0] PH_COMMAND  = 3'd1;
  localparam logic [2:0] PH_COMPRESS = 3'd2;
  localparam logic [2:0] PH_LENGTH   = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;
  localparam logic [2:0] PH_ALIVE    = 3'd6;
  localparam logic [2:0] PH_STATUS   = 3'd7;

  // Commands
  localparam logic [7:0] CMD_INIT   = 8'h01;
  localparam logic [7:0] CMD_PRINT  = 8'h02;
  localparam logic [7:0] CMD_DATA   = 8'h04;
  localparam logic [7:0] CMD_BREAK  = 8'h08;
  localparam logic [7:0] CMD_STATUS = 8'h0F;

  localparam logic [7:0] MAGIC_FIRST  = 8'h88;
  localparam logic [7:0] MAGIC_SECOND = 8'h33;
  localparam logic [7:0] REPLY_ALIVE  = 8'h81;

  // Status bit positions
  localparam int ST_CHECKSUM = 0;
  localparam int ST_BUSY     = 1;
  localparam int ST_FULL     = 2;
  localparam int ST_READY    = 3;
  localparam int ST_PKT_ERR  = 4;

  localparam int PRINT_BYTES = 4;

  // Protocol state
  logic [2:0]       phase, phase_next;
  logic             second_magic, second_magic_next;
  logic             high_expected, high_expected_next;
  logic [7:0]       command_code, command_code_next;
  logic [7:0]       length_low, length_low_next;
  logic [PW-1:0]    bytes_remaining, bytes_remaining_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_low, sum_low_next;
  logic [7:0]       status_bits, status_bits_next;
  logic [7:0]       last_reply, last_reply_next;
  logic [PW-1:0]    pending, pending_next;
  logic [CNT_W-1:0] committed, committed_next;
  logic [7:0]       captured [3];
  logic [7:0]       captured_next [3];
  logic [7:0]       margins_now, margins_now_next;
  logic             margins_valid, margins_valid_next;

  // Result register and store read
  plk_pkg::plk_out_t res, res_next;
  logic              res_valid;
  logic [7:0]        rd_q;
  logic              rd_sel, rd_sel_next;
  logic [7:0]        image_store [IMAGE_DEPTH];

  logic              accept;
  logic              is_exchange;
  logic [7:0]        b;
  logic [SUM_W-1:0]  wr_sum;
  logic              wr_ok;
  logic [CMP_W-1:0]  rd_ext;
  logic              rd_in_range;
  logic              mem_we;
  logic [15:0]       length_full;
  logic [15:0]       sum_full;
  logic [plk_pkg::DIV40_PROD_W-1:0] div_prod;
  logic [plk_pkg::DIV40_QUOT_W-1:0] div_quot;
  logic              pend_whole_lines;
  logic              pr_start;
  logic              pr_append;
  logic [7:0]        pr_margins, pr_palette, pr_exposure;

  assign req.ready   = !res_valid || rsp.ready;
  assign accept      = req.valid && req.ready;
  assign is_exchange = (req.data.operation == plk_pkg::OP_EXCHANGE);
  assign b           = req.data.link_byte;

  // Store address of the next tentative data byte
  assign wr_sum = SUM_W'(committed) + SUM_W'(pending);
  assign wr_ok  = wr_sum < SUM_W'(IMAGE_DEPTH);

  assign rd_ext      = CMP_W'(req.data.read_address);
  assign rd_in_range = rd_ext < CMP_W'(IMAGE_DEPTH);

  assign length_full = {b, length_low};
  assign sum_full    = {b, sum_low};

  // pending % 40 == 0 via reciprocal multiply
  assign div_prod = plk_pkg::DIV40_PROD_W'(pending) *
                    plk_pkg::DIV40_PROD_W'(plk_pkg::DIV40_MUL);
  assign div_quot = plk_pkg::DIV40_QUOT_W'(div_prod >> plk_pkg::DIV40_SHIFT);
  assign pend_whole_lines =
    (PW'(div_quot) * PW'(plk_pkg::LINE_BYTES)) == pending;

  always_comb begin
    phase_next           = phase;
    second_magic_next    = second_magic;
    high_expected_next   = high_expected;
    command_code_next    = command_code;
    length_low_next      = length_low;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    sum_low_next         = sum_low;
    status_bits_next     = status_bits;
    last_reply_next      = last_reply;
    pending_next         = pending;
    committed_next       = committed;
    captured_next        = captured;
    margins_now_next     = margins_now;
    margins_valid_next   = margins_valid;
    mem_we               = 1'b0;
    pr_start             = 1'b0;
    pr_append            = 1'b0;
    pr_margins           = '0;
    pr_palette           = '0;
    pr_exposure          = '0;

    if (accept && is_exchange) begin
      case (phase)
        PH_MAGIC: begin
          if (!second_magic) begin
            if (b == MAGIC_FIRST) begin
              pending_next      = '0;
              second_magic_next = 1'b1;
              last_reply_next   = '0;
            end
          end else begin
            if (b == MAGIC_SECOND) begin
              phase_next = PH_COMMAND;
            end else begin
              status_bits_next[ST_PKT_ERR] = 1'b1;
            end
            second_magic_next = 1'b0;
            last_reply_next   = '0;
          end
        end
        PH_COMMAND: begin
          if (b inside {CMD_INIT, CMD_PRINT, CMD_DATA, CMD_BREAK, CMD_STATUS}) begin
            command_code_next = b;
            running_sum_next  = 16'(b);
            phase_next        = PH_COMPRESS;
          end else begin
            status_bits_next[ST_PKT_ERR] = 1'b1;
            phase_next = PH_MAGIC;
          end
          last_reply_next = '0;
        end
        PH_COMPRESS: begin
          running_sum_next = running_sum + 16'(b);
          phase_next       = PH_LENGTH;
          last_reply_next  = '0;
        end
        PH_LENGTH: begin
          running_sum_next = running_sum + 16'(b);
          if (!high_expected) begin
            length_low_next    = b;
            high_expected_next = 1'b1;
          end else begin
            high_expected_next = 1'b0;
            if (length_full <= 16'(plk_pkg::MAX_PACKET_LENGTH)) begin
              bytes_remaining_next = length_full[PW-1:0];
              if ((command_code == CMD_PRINT || command_code == CMD_DATA) &&
                  length_full[PW-1:0] != '0) begin
                phase_next = PH_DATA;
              end else begin
                phase_next = PH_CHECKSUM;
              end
            end else begin
              status_bits_next[ST_PKT_ERR] = 1'b1;
              phase_next = PH_MAGIC;
            end
          end
          last_reply_next = '0;
        end
        PH_DATA: begin
          running_sum_next = running_sum + 16'(b);
          mem_we           = wr_ok;
          if (pending >= PW'(1) && pending <= PW'(3)) begin
            captured_next[pending[1:0] - 2'd1] = b;
          end
          if (pending != '1) begin
            pending_next = pending + PW'(1);
          end
          if (bytes_remaining <= PW'(1)) begin
            bytes_remaining_next = '0;
            phase_next           = PH_CHECKSUM;
          end else begin
            bytes_remaining_next = bytes_remaining - PW'(1);
          end
          last_reply_next = '0;
        end
        PH_CHECKSUM: begin
          if (!high_expected) begin
            sum_low_next       = b;
            high_expected_next = 1'b1;
          end else begin
            high_expected_next = 1'b0;
            status_bits_next[ST_CHECKSUM] = (running_sum != sum_full);
            phase_next = PH_ALIVE;
          end
          last_reply_next = '0;
        end
        PH_ALIVE: begin
          last_reply_next = REPLY_ALIVE;
          phase_next      = PH_STATUS;
        end
        PH_STATUS: begin
          // Status slot: reply with the current status, then run the command
          last_reply_next = status_bits;
          phase_next      = PH_MAGIC;
          case (command_code)
            CMD_INIT, CMD_BREAK: begin
              pending_next     = '0;
              committed_next   = '0;
              status_bits_next = '0;
            end
            CMD_PRINT: begin
              if (pending != PW'(PRINT_BYTES)) begin
                pending_next   = '0;
                committed_next = '0;
                status_bits_next[ST_PKT_ERR] = 1'b1;
              end else begin
                status_bits_next[ST_READY] = 1'b0;
                status_bits_next[ST_BUSY]  = 1'b1;
                status_bits_next[ST_FULL]  = 1'b1;
                pr_start    = 1'b1;
                pr_margins  = captured[0];
                pr_palette  = captured[1];
                pr_exposure = captured[2];
                pr_append   = margins_valid && (margins_now[3:0] == 4'h0) &&
                              (captured[0][7:4] == 4'h0);
                margins_now_next   = captured[0];
                margins_valid_next = 1'b1;
                pending_next       = '0;
              end
            end
            CMD_DATA: begin
              if (pend_whole_lines) begin
                status_bits_next[ST_READY] = 1'b1;
                committed_next = (wr_sum > SUM_W'(IMAGE_DEPTH)) ?
                                 CNT_W'(IMAGE_DEPTH) : wr_sum[CNT_W-1:0];
              end else begin
                committed_next = '0;
                status_bits_next[ST_PKT_ERR] = 1'b1;
              end
              pending_next = '0;
            end
            CMD_STATUS: begin
              pending_next = '0;
              if (status_bits[ST_FULL] && status_bits[ST_BUSY] &&
                  !status_bits[ST_PKT_ERR]) begin
                status_bits_next[ST_BUSY] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          phase_next = PH_MAGIC;
        end
      endcase
    end
  end

  // Result fields; read_data is filled from the registered store read
  always_comb begin
    res_next                 = res;
    res_next.reply_byte      = last_reply_next;
    res_next.read_data       = '0;
    res_next.status_now      = status_bits_next;
    res_next.print_start     = pr_start;
    res_next.print_margins   = pr_margins;
    res_next.print_palette   = pr_palette;
    res_next.print_exposure  = pr_exposure;
    res_next.print_appending = pr_append;
    res_next.image_length    = plk_pkg::IMG_LEN_W'(committed_next);
    rd_sel_next              = !is_exchange && rd_in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      second_magic    <= 1'b0;
      high_expected   <= 1'b0;
      command_code    <= '0;
      length_low      <= '0;
      bytes_remaining <= '0;
      running_sum     <= '0;
      sum_low         <= '0;
      status_bits     <= '0;
      last_reply      <= '0;
      pending         <= '0;
      committed       <= '0;
      captured        <= '{default: '0};
      margins_now     <= '0;
      margins_valid   <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      second_magic    <= second_magic_next;
      high_expected   <= high_expected_next;
      command_code    <= command_code_next;
      length_low      <= length_low_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
      sum_low         <= sum_low_next;
      status_bits     <= status_bits_next;
      last_reply      <= last_reply_next;
      pending         <= pending_next;
      committed       <= committed_next;
      captured        <= captured_next;
      margins_now     <= margins_now_next;
      margins_valid   <= margins_valid_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload side of the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      res    <= res_next;
      rd_sel <= rd_sel_next;
    end
  end

  // Image store: one write port for data bytes, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      image_store[wr_sum[ADDR_W-1:0]] <= b;
    end
    if (accept && !is_exchange) begin
      rd_q <= image_store[rd_ext[ADDR_W-1:0]];
    end
  end

  assign rsp.valid = res_valid;

  always_comb begin
    rsp.data           = res;
    rsp.data.read_data = rd_sel ? rd_q : 8'h00;
  end

`ifndef SYNTHESIS
  // A PRINT always reports busy in the same item
  a_print_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.print_start |-> rsp.data.status_now[ST_BUSY])
    else $error("print_start without busy status");

  // Committed length never exceeds the store
  a_commit_bound: assert property (@(posedge clk) disable iff (rst)
    committed <= CNT_W'(IMAGE_DEPTH))
    else $error("committed length beyond store depth");

  // Tentative data of one packet never exceeds the packet length limit
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(plk_pkg::MAX_PACKET_LENGTH))
    else $error("pending count beyond packet limit");

  // Store read data held while a result waits
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(rd_q) && $stable(rd_sel))
    else $error("store read data changed under stall");
`endif

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the printer link packet engine.
`default_nettype none
module testbench;

  localparam int DEPTH        = plk_pkg::IMAGE_DEPTH_DEF;
  localparam int ITEMS_TARGET = 650;
  localparam int TAIL_ITEMS   = 160;    // room kept for the close-out packets and reads

  localparam logic [7:0] MAGIC_LEAD  = 8'h88;
  localparam logic [7:0] MAGIC_TRAIL = 8'h33;
  localparam logic [7:0] ALIVE_REPLY = 8'h81;
  localparam logic [7:0] CMD_INIT    = 8'h01;
  localparam logic [7:0] CMD_PRINT   = 8'h02;
  localparam logic [7:0] CMD_DATA    = 8'h04;
  localparam logic [7:0] CMD_BREAK   = 8'h08;
  localparam logic [7:0] CMD_STATUS  = 8'h0F;
  localparam logic [7:0] CMD_BOGUS   = 8'hFF;
  localparam logic [7:0] ST_CKSUM    = 8'h01;
  localparam logic [7:0] ST_BUSY     = 8'h02;
  localparam logic [7:0] ST_FULL     = 8'h04;
  localparam logic [7:0] ST_READY    = 8'h08;
  localparam logic [7:0] ST_PKT_ERR  = 8'h10;

  typedef enum logic [2:0] {
    LP_MAGIC, LP_COMMAND, LP_COMPRESS, LP_LENGTH, LP_DATA, LP_CHECKSUM, LP_ALIVE, LP_STATUS
  } link_phase_e;

  typedef struct {
    bit                on;
    plk_pkg::plk_out_t val;
  } pinned_t;

  // directed rows: link byte, whether the reply is typed in, typed reply and status
  typedef struct packed {
    logic [7:0] link_byte;
    logic       pinned;
    logic [7:0] reply;
    logic [7:0] status;
  } probe_row_t;

  localparam probe_row_t PROBE_ROWS [22] = '{
    '{8'hFF,       1'b1, 8'h00, 8'h00},        // stray byte right after reset
    '{MAGIC_LEAD,  1'b0, 8'h00, 8'h00},
    '{8'h00,       1'b1, 8'h00, ST_PKT_ERR},   // wrong second magic
    '{MAGIC_LEAD,  1'b0, 8'h00, 8'h00},
    '{MAGIC_TRAIL, 1'b0, 8'h00, 8'h00},
    '{CMD_BOGUS,   1'b1, 8'h00, ST_PKT_ERR},   // unknown command
    '{MAGIC_LEAD,  1'b0, 8'h00, 8'h00},
    '{MAGIC_TRAIL, 1'b0, 8'h00, 8'h00},
    '{CMD_DATA,    1'b0, 8'h00, 8'h00},
    '{8'h00,       1'b0, 8'h00, 8'h00},
    '{8'h81,       1'b0, 8'h00, 8'h00},
    '{8'h02,       1'b1, 8'h00, ST_PKT_ERR},   // length 641, one past the limit
    '{MAGIC_LEAD,  1'b0, 8'h00, 8'h00},
    '{MAGIC_TRAIL, 1'b0, 8'h00, 8'h00},
    '{CMD_PRINT,   1'b0, 8'h00, 8'h00},
    '{8'h07,       1'b0, 8'h00, 8'h00},        // compression flag neither 0 nor 1
    '{8'h00,       1'b0, 8'h00, 8'h00},
    '{8'h00,       1'b0, 8'h00, 8'h00},        // PRINT length 0: straight to checksum
    '{8'h09,       1'b0, 8'h00, 8'h00},
    '{8'h00,       1'b0, 8'h00, 8'h00},
    '{8'h00,       1'b1, ALIVE_REPLY, ST_PKT_ERR},
    '{8'hFF,       1'b1, ST_PKT_ERR, ST_PKT_ERR} // PRINT without 4 bytes keeps the error
  };

  logic clk = 1'b0;
  logic rst;
  logic idle_on;

  plk_stream_if #(.item_t(plk_pkg::plk_in_t))  req_if ();
  plk_stream_if #(.item_t(plk_pkg::plk_out_t)) rsp_if ();

  printer_link_packet_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  link_phase_e m_phase       = LP_MAGIC;
  bit          m_second      = 1'b0;   // waiting for the second magic byte
  bit          m_hi_next     = 1'b0;   // next length/checksum byte is the high one
  logic [7:0]  m_cmd         = '0;
  bit          m_compress    = 1'b0;
  logic [15:0] m_len         = '0;
  int          m_left        = 0;
  logic [15:0] m_sum         = '0;
  logic [15:0] m_rx_sum      = '0;
  logic [7:0]  m_status      = '0;
  logic [7:0]  m_reply       = '0;
  int          m_pending     = 0;
  int          m_committed   = 0;
  logic [7:0]  m_capt [3]    = '{8'h00, 8'h00, 8'h00};
  logic [7:0]  m_margin_cur  = '0;
  bit          m_margin_seen = 1'b0;
  logic [7:0]  m_store [DEPTH];
  int          m_store_fill  = 0;      // store is written as a prefix, this is its end

  pinned_t           pinned_q [$];
  plk_pkg::plk_out_t link_results_q [$];
  int fail_count      = 0;
  int results_checked = 0;
  int link_items      = 0;
  int store_reads     = 0;
  int packets_sent    = 0;
  int print_pulses    = 0;
  int store_peak      = 0;

  function automatic plk_pkg::plk_out_t link_engine_step(input plk_pkg::plk_in_t it);
    plk_pkg::plk_out_t r;
    logic [7:0]        b;
    int                wr_addr;
    r = '0;
    b = it.link_byte;
    if (it.operation == plk_pkg::OP_READ) begin
      r.read_data = m_store[it.read_address];
    end else begin
      case (m_phase)
        LP_MAGIC: begin
          if (!m_second) begin
            if (b == MAGIC_LEAD) begin
              m_pending = 0;
              m_second  = 1'b1;
              m_reply   = '0;
            end
          end else begin
            if (b == MAGIC_TRAIL) m_phase = LP_COMMAND;
            else m_status |= ST_PKT_ERR;
            m_second = 1'b0;
            m_reply  = '0;
          end
        end
        LP_COMMAND: begin
          if (b inside {CMD_INIT, CMD_PRINT, CMD_DATA, CMD_BREAK, CMD_STATUS}) begin
            m_cmd   = b;
            m_sum   = {8'h00, b};
            m_phase = LP_COMPRESS;
          end else begin
            m_status |= ST_PKT_ERR;
            m_phase = LP_MAGIC;
          end
          m_reply = '0;
        end
        LP_COMPRESS: begin
          if (b == 8'h01) m_compress = 1'b1;
          else if (b == 8'h00) m_compress = 1'b0;
          m_sum   = m_sum + 16'(b);
          m_phase = LP_LENGTH;
          m_reply = '0;
        end
        LP_LENGTH: begin
          m_sum = m_sum + 16'(b);
          if (!m_hi_next) begin
            m_len     = {8'h00, b};
            m_hi_next = 1'b1;
          end else begin
            m_len[15:8] = b;
            m_hi_next   = 1'b0;
            if (int'(m_len) <= plk_pkg::MAX_PACKET_LENGTH) begin
              m_left = int'(m_len);
              if ((m_cmd == CMD_PRINT || m_cmd == CMD_DATA) && m_left != 0) m_phase = LP_DATA;
              else m_phase = LP_CHECKSUM;
            end else begin
              m_status |= ST_PKT_ERR;
              m_phase = LP_MAGIC;
            end
          end
          m_reply = '0;
        end
        LP_DATA: begin
          // tentative write just past the committed bytes
          wr_addr = m_committed + m_pending;
          m_sum = m_sum + 16'(b);
          if (wr_addr < DEPTH) begin
            m_store[13'(wr_addr)] = b;
            if (wr_addr >= m_store_fill) m_store_fill = wr_addr + 1;
          end
          if (m_pending >= 1 && m_pending <= 3) m_capt[2'(m_pending - 1)] = b;
          if (m_pending < 1023) m_pending++;
          if (m_left != 0) m_left--;
          if (m_left == 0) m_phase = LP_CHECKSUM;
          m_reply = '0;
        end
        LP_CHECKSUM: begin
          if (!m_hi_next) begin
            m_rx_sum  = {8'h00, b};
            m_hi_next = 1'b1;
          end else begin
            m_rx_sum[15:8] = b;
            m_hi_next = 1'b0;
            if (m_sum != m_rx_sum) m_status |= ST_CKSUM;
            else m_status &= ~ST_CKSUM;
            m_phase = LP_ALIVE;
          end
          m_reply = '0;
        end
        LP_ALIVE: begin
          m_reply = ALIVE_REPLY;
          m_phase = LP_STATUS;
        end
        default: begin
          // status slot: reply with the old status, then the command runs
          m_reply = m_status;
          case (m_cmd)
            CMD_INIT, CMD_BREAK: begin
              m_pending   = 0;
              m_committed = 0;
              m_status    = '0;
            end
            CMD_PRINT: begin
              if (m_pending != 4) begin
                m_pending   = 0;
                m_committed = 0;
                m_status |= ST_PKT_ERR;
              end else begin
                m_status = (m_status & ~ST_READY) | ST_BUSY | ST_FULL;
                r.print_start    = 1'b1;
                r.print_margins  = m_capt[0];
                r.print_palette  = m_capt[1];
                r.print_exposure = m_capt[2];
                r.print_appending = m_margin_seen && m_margin_cur[3:0] == 4'h0 &&
                                    m_capt[0][7:4] == 4'h0;
                m_margin_cur  = m_capt[0];
                m_margin_seen = 1'b1;
                m_pending     = 0;
                print_pulses++;
              end
            end
            CMD_DATA: begin
              if (m_pending % plk_pkg::LINE_BYTES == 0) begin
                m_status |= ST_READY;
                m_committed = (m_committed + m_pending > DEPTH) ? DEPTH :
                              m_committed + m_pending;
              end else begin
                m_committed = 0;
                m_status |= ST_PKT_ERR;
              end
              m_pending = 0;
            end
            CMD_STATUS: begin
              m_pending = 0;
              if ((m_status & ST_FULL) != 0 && (m_status & ST_BUSY) != 0 &&
                  (m_status & ST_PKT_ERR) == 0)
                m_status &= ~ST_BUSY;
            end
            default: ;
          endcase
          m_phase = LP_MAGIC;
        end
      endcase
    end
    if (m_committed > store_peak) store_peak = m_committed;
    r.reply_byte   = m_reply;
    r.status_now   = m_status;
    r.image_length = m_committed[plk_pkg::IMG_LEN_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Monitor: results are compared before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    plk_pkg::plk_out_t want;
    plk_pkg::plk_out_t got;
    pinned_t           pin;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (link_results_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, got %h", $time, got);
        end else begin
          want = link_results_q.pop_front();
          check_field("reply_byte", 16'(want.reply_byte), 16'(got.reply_byte));
          check_field("read_data", 16'(want.read_data), 16'(got.read_data));
          check_field("status_now", 16'(want.status_now), 16'(got.status_now));
          check_field("print_start", 16'(want.print_start), 16'(got.print_start));
          check_field("print_margins", 16'(want.print_margins), 16'(got.print_margins));
          check_field("print_palette", 16'(want.print_palette), 16'(got.print_palette));
          check_field("print_exposure", 16'(want.print_exposure),
                      16'(got.print_exposure));
          check_field("print_appending", 16'(want.print_appending),
                      16'(got.print_appending));
          check_field("image_length", 16'(want.image_length), 16'(got.image_length));
          results_checked++;
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = link_engine_step(req_if.data);
        pin  = pinned_q.pop_front();
        if (pin.on) want = pin.val;
        link_results_q = {link_results_q, want};
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, mostly short.
  initial begin
    int sink_hold;
    sink_hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) sink_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic op, input logic [7:0] b, input logic [12:0] addr,
                           input bit pinned, input plk_pkg::plk_out_t pin_val);
    plk_pkg::plk_in_t it;
    pinned_t          pin;
    it.operation    = op;
    it.link_byte    = b;
    it.read_address = addr;
    pin.on  = pinned;
    pin.val = pin_val;
    pinned_q = {pinned_q, pin};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(plk_pkg::OP_EXCHANGE, b, 13'($urandom), 1'b0, '0);
    link_items++;
  endtask

  task automatic send_read(input logic [12:0] addr);
    push_item(plk_pkg::OP_READ, 8'($urandom), addr, 1'b0, '0);
    store_reads++;
  endtask

  // Sender holds off until every expected result is back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (link_results_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_flag();
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_cmd();
    case ($urandom_range(0, 4))
      0: return CMD_INIT;
      1: return CMD_PRINT;
      2: return CMD_DATA;
      3: return CMD_BREAK;
      default: return CMD_STATUS;
    endcase
  endfunction

  // One packet with random payload, cut short when cut is set; reads of written store bytes are mixed in.
  task automatic send_packet(input logic [7:0] cmd, input logic [7:0] flag, input int len,
                             input bit ck_ok, input bit cut);
    logic [7:0]  pkt [$];
    logic [15:0] sum;
    logic [7:0]  d;
    int          n_data;
    pkt = {MAGIC_LEAD, MAGIC_TRAIL, cmd, flag, len[7:0], len[15:8]};
    sum = 16'(cmd) + 16'(flag) + 16'(len[7:0]) + 16'(len[15:8]);
    if (len <= plk_pkg::MAX_PACKET_LENGTH) begin
      n_data = (cmd == CMD_PRINT || cmd == CMD_DATA) ? len : 0;
      for (int i = 0; i < n_data; i++) begin
        d = 8'($urandom);
        // margins byte: often leave one nibble zero so appending can occur
        if (cmd == CMD_PRINT && i == 1 && $urandom_range(0, 1) == 1)
          d = $urandom_range(0, 1) ? {4'h0, 4'($urandom)} : {4'($urandom), 4'h0};
        pkt = {pkt, d};
        sum = sum + 16'(d);
      end
      if (!ck_ok) sum ^= 16'($urandom_range(1, 16'hFFFF));
      pkt = {pkt, sum[7:0]};
      pkt = {pkt, sum[15:8]};
      pkt = {pkt, 8'($urandom)};   // alive slot
      pkt = {pkt, 8'($urandom)};   // status slot
    end
    if (cut) pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
    foreach (pkt[i]) begin
      if (m_store_fill > 0 && $urandom_range(0, 15) == 0)
        send_read(13'($urandom_range(0, m_store_fill - 1)));
      send_byte(pkt[i]);
    end
    packets_sent++;
  endtask

  function automatic int pick_data_length();
    int l;
    case ($urandom_range(0, 19))
      0: return 0;
      1: return plk_pkg::LINE_BYTES * $urandom_range(4, 16);
      2, 3: begin
        l = $urandom_range(1, 200);
        if (l % plk_pkg::LINE_BYTES == 0) l++;
        return l;
      end
      default: return plk_pkg::LINE_BYTES * $urandom_range(1, 2);
    endcase
  endfunction

  // The usual job: an optional clear, up to three image data packets, print, one or two status polls.
  task automatic print_job();
    if ($urandom_range(0, 2) != 0)
      send_packet($urandom_range(0, 1) ? CMD_INIT : CMD_BREAK, rand_flag(),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, plk_pkg::MAX_PACKET_LENGTH) : 0,
                  1'b1, 1'b0);
    repeat ($urandom_range(0, 3))
      send_packet(CMD_DATA, rand_flag(), pick_data_length(), $urandom_range(0, 9) != 0, 1'b0);
    send_packet(CMD_PRINT, rand_flag(), $urandom_range(0, 7) == 0 ? $urandom_range(0, 8) : 4,
                $urandom_range(0, 9) != 0, 1'b0);
    repeat ($urandom_range(1, 2))
      send_packet(CMD_STATUS, rand_flag(), $urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0,
                  1'b1, 1'b0);
  endtask

  // Broken traffic: stray bytes, bad magic, bad command, cut-off packets.
  task automatic send_noise();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom);
        if (b == MAGIC_LEAD) b = 8'h00;
        push_item(plk_pkg::OP_EXCHANGE, b, 13'($urandom), 1'b0, '0);   // not counted as link bytes
      end
      1: begin
        b = 8'($urandom);
        if (b == MAGIC_TRAIL) b = ~b;
        send_byte(MAGIC_LEAD);
        send_byte(b);
      end
      2: begin
        b = 8'($urandom);
        while (b inside {CMD_INIT, CMD_PRINT, CMD_DATA, CMD_BREAK, CMD_STATUS}) b = 8'($urandom);
        send_byte(MAGIC_LEAD);
        send_byte(MAGIC_TRAIL);
        send_byte(b);
      end
      default: send_packet(rand_cmd(), rand_flag(), $urandom_range(0, 12), 1'b1, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    plk_pkg::plk_out_t pin_val;
    int                base;
    rst          <= 1'b1;
    idle_on      <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: error paths and the zero-length PRINT
    foreach (PROBE_ROWS[i]) begin
      pin_val = '0;
      pin_val.reply_byte = PROBE_ROWS[i].reply;
      pin_val.status_now = PROBE_ROWS[i].status;
      push_item(plk_pkg::OP_EXCHANGE, PROBE_ROWS[i].link_byte, 13'($urandom),
                PROBE_ROWS[i].pinned, pin_val);
      link_items++;
    end
    wait_drained();

    // random jobs with noise; idling is switched off for some packets
    base = link_items + store_reads;
    while (link_items + store_reads - base < ITEMS_TARGET - TAIL_ITEMS) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: print_job();
        6, 7: send_noise();
        default: send_packet(rand_cmd(), rand_flag(),
                             $urandom_range(0, 15) == 0 ? $urandom_range(641, 65535) :
                                                          $urandom_range(0, 64),
                             $urandom_range(0, 4) != 0, 1'b0);
      endcase
    end
    wait_drained();

    // close-out: fresh image, two committed lines, reads of written bytes, print and poll
    idle_on <= 1'b1;
    send_packet(CMD_INIT, 8'h00, 0, 1'b1, 1'b0);
    send_packet(CMD_DATA, 8'h00, 2 * plk_pkg::LINE_BYTES, 1'b1, 1'b0);
    if (m_store_fill > 0) begin
      send_read(13'(m_store_fill - 1));
      repeat (8) send_read(13'($urandom_range(0, m_store_fill - 1)));
    end
    send_packet(CMD_PRINT, 8'h00, 4, 1'b1, 1'b0);
    send_packet(CMD_STATUS, 8'h00, 0, 1'b1, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (link_results_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, link_results_q.size());
    end
    $display("covered %0d link bytes in %0d packets and %0d store reads; %0d results compared",
             link_items, packets_sent, store_reads, results_checked);
    $display("print pulses %0d, committed image peaked at %0d of %0d bytes",
             print_pulses, store_peak, DEPTH);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #32_000_000;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
